// ===== sv/ipmac_pkg.sv =====
// ----------------------------------------------------------------------------
// ipmac_pkg
// Shared constants, codes and controller/datapath structs of the IPv4-to-MAC
// resolution cache.
// ----------------------------------------------------------------------------
`default_nettype none

package ipmac_pkg;

  localparam int ENTRIES = 64;
  localparam int AW      = $clog2(ENTRIES);

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int CMD_W   = 2;
  localparam int OUTC_W  = 2;

  // stream widths, rounded up to whole bytes
  localparam int IN_BITS  = CMD_W + IP_W + MAC_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + MAC_W + OUTC_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_UPDATED  = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_NEW      = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_REPLACED = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_IGNORED  = 2'd3;

  localparam logic [IP_W-1:0]  BCAST_IP  = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] BCAST_MAC = {6{8'hFF}};

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch new item, clear scan flags
    logic issue;   // read table at scan index, advance index
    logic write;   // store item at chosen slot
    logic load;    // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;  // incoming item needs a table scan
    logic is_insert;  // held item is an insert
    logic scan_last;  // scan index at last entry
    logic out_busy;   // output register still holds an untaken result
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== sv/ipmac_ram.sv =====
// ----------------------------------------------------------------------------
// ipmac_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ipmac_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipmac_ctrl
// Sequencer of the resolution cache: accept, scan, drain, write, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmac_ctrl
  import ipmac_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read compares here
      ST_DRAIN: begin
        state_d = sts_i.is_insert ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ipmac_dp.sv =====
// ----------------------------------------------------------------------------
// ipmac_dp
// Datapath of the resolution cache: address/MAC tables, valid bits, scan
// compare, slot choice and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipmac_dp
  import ipmac_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata,
  input  wire ctrl_cmd_t        cmd_i,
  output ctrl_sts_t             sts_o
);

  logic [CMD_W-1:0] in_cmd;
  logic [IP_W-1:0]  in_ip;
  logic [MAC_W-1:0] in_mac;

  assign in_cmd = s_axis_tdata[CMD_W-1:0];
  assign in_ip  = s_axis_tdata[CMD_W+IP_W-1:CMD_W];
  assign in_mac = s_axis_tdata[CMD_W+IP_W+MAC_W-1:CMD_W+IP_W];

  logic [CMD_W-1:0] cmd_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;

  logic [AW-1:0]    idx_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_idx_q;

  logic             hit_q, free_q;
  logic [AW-1:0]    hit_idx_q, free_idx_q;
  logic [MAC_W-1:0] hit_mac_q;

  logic [ENTRIES-1:0] valid_q;

  logic             out_vld_q;
  logic [OUT_W-1:0] out_data_q;

  logic [IP_W-1:0]  ip_rdata;
  logic [MAC_W-1:0] mac_rdata;
  logic [AW-1:0]    wr_idx;
  logic             ent_valid, ent_match;

  // need_scan for the item at the input
  always_comb begin
    sts_o.need_scan = 1'b0;
    case (in_cmd)
      CMD_LOOKUP: sts_o.need_scan = (in_ip != '0) && (in_ip != BCAST_IP);
      CMD_INSERT: sts_o.need_scan = (in_ip != '0);
      default:    sts_o.need_scan = 1'b0;
    endcase
  end

  assign sts_o.is_insert = (cmd_q == CMD_INSERT);
  assign sts_o.scan_last = (idx_q == AW'(ENTRIES - 1));
  assign sts_o.out_busy  = out_vld_q && !m_axis_tready;

  ipmac_ram #(.WIDTH(IP_W), .DEPTH(ENTRIES)) u_ip_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (wr_idx),
    .wdata_i (ip_q),
    .re_i    (cmd_i.issue),
    .raddr_i (idx_q),
    .rdata_o (ip_rdata)
  );

  ipmac_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES)) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (wr_idx),
    .wdata_i (mac_q),
    .re_i    (cmd_i.issue),
    .raddr_i (idx_q),
    .rdata_o (mac_rdata)
  );

  assign ent_valid = valid_q[rd_idx_q];
  assign ent_match = ent_valid && (ip_rdata == ip_q);

  // matching slot first, then lowest free slot, else slot 0
  always_comb begin
    if (hit_q) begin
      wr_idx = hit_idx_q;
    end else if (free_q) begin
      wr_idx = free_idx_q;
    end else begin
      wr_idx = '0;
    end
  end

  // result fields
  logic             res_found;
  logic [MAC_W-1:0] res_mac;
  logic [OUTC_W-1:0] res_outc;

  always_comb begin
    res_found = 1'b0;
    res_mac   = '0;
    res_outc  = OUT_IGNORED;
    case (cmd_q)
      CMD_LOOKUP: begin
        if (ip_q == BCAST_IP) begin
          res_found = 1'b1;
          res_mac   = BCAST_MAC;
        end else if (ip_q != '0 && hit_q) begin
          res_found = 1'b1;
          res_mac   = hit_mac_q;
        end
      end
      CMD_INSERT: begin
        if (ip_q == '0) begin
          res_outc = OUT_IGNORED;
        end else if (hit_q) begin
          res_outc = OUT_UPDATED;
        end else if (free_q) begin
          res_outc = OUT_NEW;
        end else begin
          res_outc = OUT_REPLACED;
        end
      end
      default: begin
        res_outc = OUT_IGNORED;
      end
    endcase
  end

  // item registers and scan results (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_cmd;
      ip_q  <= in_ip;
      mac_q <= in_mac;
    end
    rd_idx_q <= idx_q;
    if (rd_vld_q && ent_match && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      hit_mac_q <= mac_rdata;
    end
    if (rd_vld_q && !ent_valid && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.load) begin
      out_data_q <= OUT_W'({res_outc, res_mac, res_found});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.accept) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_q + 1'b1;
        end
        if (rd_vld_q && ent_match) begin
          hit_q <= 1'b1;
        end
        if (rd_vld_q && !ent_valid) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.write) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.load) begin
        out_vld_q <= 1'b1;
        if (cmd_q == CMD_CLEAR) begin
          valid_q <= '0;
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/ip_to_mac_resolution_cache_top.sv =====
// ----------------------------------------------------------------------------
// ip_to_mac_resolution_cache_top
// IPv4-to-MAC resolution cache: lookup, insert/update and clear on a table.
//
//   channel   direction  tdata fields (lsb up)
//   s_axis    in         command[1:0], ip_addr[33:2], mac_in[81:34]
//   m_axis    out        found[0], mac_out[48:1], insert_outcome[50:49]
//
// Lookup/insert items scan every slot through one table read port, and an
// insert then writes its chosen slot. Clear, code 3, zero address and
// broadcast lookup skip the scan. One item in flight; the next one is taken
// while the previous result waits in the output register.
// Reset invalidates all slots at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_to_mac_resolution_cache_top
  import ipmac_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // command, ip_addr, mac_in
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata    // found, mac_out, insert_outcome
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ipmac_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ipmac_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

// ===== verif/tb_ip_to_mac_resolution_cache_top.sv =====
// ----------------------------------------------------------------------------
// tb_ip_to_mac_resolution_cache_top
// Self-checking bench for the IPv4-to-MAC resolution cache. Drives lookup,
// insert, clear and unused-code items on the input stream. A local table
// model predicts every reply, which is checked field by field at the output.
// Sender bursts and receiver stalls are random. A long output hold-off and
// a full drain pause are forced at least once.
// ----------------------------------------------------------------------------
module tb_ip_to_mac_resolution_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipmac_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;
  localparam int               POOL_SIZE   = 96;
  localparam int               CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic                found;
    logic [MAC_W-1:0]    mac;
    logic [OUTC_W-1:0]   outcome;
  } cache_reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  // local copy of the address table
  logic [IP_W-1:0]  tbl_ip    [ENTRIES];
  logic [MAC_W-1:0] tbl_mac   [ENTRIES];
  bit               tbl_valid [ENTRIES];

  cache_reply_t     reply_q[$];
  logic [IP_W-1:0]  addr_pool [POOL_SIZE];
  int               err_count      = 0;
  int               cycle_cnt      = 0;
  int               rx_hold_cycles = 0;
  int               burst_left     = 0;
  bit               tx_gappy       = 1'b0;

  ip_to_mac_resolution_cache_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // table model: applies one command and returns the reply it produces
  // --------------------------------------------------------------------------
  function automatic int match_slot(input logic [IP_W-1:0] ip);
    int slot;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && tbl_valid[i] && tbl_ip[i] == ip) slot = i;
    return slot;
  endfunction

  function automatic cache_reply_t apply_cmd(input logic [CMD_W-1:0] cmd,
                                             input logic [IP_W-1:0]  ip,
                                             input logic [MAC_W-1:0] mac);
    cache_reply_t r;
    int           slot;
    r.found   = 1'b0;
    r.mac     = '0;
    r.outcome = OUT_IGNORED;
    case (cmd)
      CMD_LOOKUP: begin
        if (ip == {IP_W{1'b1}}) begin
          r.found = 1'b1;
          r.mac   = {MAC_W{1'b1}};
        end else if (ip != '0) begin
          slot = match_slot(ip);
          if (slot >= 0) begin
            r.found = 1'b1;
            r.mac   = tbl_mac[slot];
          end
        end
      end
      CMD_INSERT: begin
        if (ip != '0) begin
          slot = match_slot(ip);
          if (slot >= 0) begin
            tbl_mac[slot] = mac;
            r.outcome     = OUT_UPDATED;
          end else begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot >= 0) begin
              r.outcome = OUT_NEW;
            end else begin
              slot      = 0;
              r.outcome = OUT_REPLACED;
            end
            tbl_ip[slot]    = ip;
            tbl_mac[slot]   = mac;
            tbl_valid[slot] = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("[%0t] mismatch %s: got 0x%0h exp 0x%0h", $realtime, what, got, exp);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // reply checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_reply
    cache_reply_t got;
    cache_reply_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found   = m_axis_tdata[0];
      got.mac     = m_axis_tdata[MAC_W:1];
      got.outcome = m_axis_tdata[MAC_W+OUTC_W:MAC_W+1];
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected item", 64'(got), 64'd0);
      end else begin
        exp = reply_q.pop_front();
        if (got.found !== exp.found)
          report_mismatch("found", 64'(got.found), 64'(exp.found));
        if (got.mac !== exp.mac)
          report_mismatch("mac_out", 64'(got.mac), 64'(exp.mac));
        if (got.outcome !== exp.outcome)
          report_mismatch("insert_outcome", 64'(got.outcome), 64'(exp.outcome));
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall modes, plus a forced hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int rx_mode;
    int rx_run;
    rx_mode       = 0;
    rx_run        = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        if (rx_run == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_run  = $urandom_range(10, 150);
        end
        rx_run--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac);
    int gap;
    if (tx_gappy && burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({mac, ip, cmd});
    do @(posedge clk_i); while (!s_axis_tready);
    reply_q.push_back(apply_cmd(cmd, ip, mac));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    return r64[MAC_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    logic [IP_W-1:0] ip_a;
    logic [IP_W-1:0] ip_b;
    logic [IP_W-1:0] ip_c;
    ip_a = 32'h0A00_0001;
    ip_b = 32'h0000_0001;
    ip_c = 32'hFFFF_FFFE;
    send_item(CMD_LOOKUP, ip_a, rand_mac());           // empty table miss
    send_item(CMD_LOOKUP, '0, rand_mac());
    send_item(CMD_LOOKUP, BCAST_IP, '0);
    send_item(CMD_INSERT, '0, rand_mac());             // zero address ignored
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_INSERT, BCAST_IP, 48'h1234_5678_9ABC); // stored, not returned
    send_item(CMD_LOOKUP, BCAST_IP, '0);
    send_item(CMD_INSERT, ip_a, {MAC_W{1'b1}});
    send_item(CMD_INSERT, ip_a, '0);                   // update
    send_item(CMD_LOOKUP, ip_a, rand_mac());
    send_item(CMD_INSERT, ip_b, 48'hAAAA_AAAA_AAAA);
    send_item(CMD_INSERT, ip_c, 48'h5555_5555_5555);
    send_item(CMD_LOOKUP, ip_b, '0);
    send_item(CMD_LOOKUP, ip_c, '0);
    send_item(CMD_NOP, ip_a, rand_mac());
    send_item(CMD_LOOKUP, ip_a, '0);
    send_item(CMD_CLEAR, ip_a, rand_mac());
    send_item(CMD_LOOKUP, ip_a, '0);
    send_item(CMD_INSERT, ip_c, 48'h0000_0000_0001);   // lands in slot 0
    send_item(CMD_LOOKUP, ip_c, '0);
    send_item(CMD_LOOKUP, ip_b, '0);
    wait_drained();
  endtask

  task automatic test_table_full();
    send_item(CMD_CLEAR, '0, '0);
    for (int i = 0; i < ENTRIES; i++) send_item(CMD_INSERT, addr_pool[i], rand_mac());
    send_item(CMD_INSERT, addr_pool[ENTRIES], rand_mac());   // evicts slot 0
    send_item(CMD_LOOKUP, addr_pool[0], '0);
    send_item(CMD_LOOKUP, addr_pool[ENTRIES], '0);
    send_item(CMD_LOOKUP, addr_pool[ENTRIES-1], '0);
    send_item(CMD_INSERT, addr_pool[ENTRIES-1], rand_mac());
    send_item(CMD_INSERT, addr_pool[ENTRIES+1], rand_mac());
    send_item(CMD_LOOKUP, addr_pool[ENTRIES+1], '0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_gappy       = 1'b0;
    rx_hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_item((i % 2 == 0) ? CMD_INSERT : CMD_LOOKUP, addr_pool[i % 8], rand_mac());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int               span;
    int               n_items;
    int               sel;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [CMD_W-1:0] op;
    for (int phase = 0; phase < 4; phase++) begin
      span     = (phase == 0) ? 20 : POOL_SIZE;
      tx_gappy = (phase != 2);
      n_items  = (phase == 3) ? 170 : 130;
      for (int n = 0; n < n_items; n++) begin
        sel = $urandom_range(0, 99);
        ip  = addr_pool[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 9))
          0:       mac = '0;
          1:       mac = {MAC_W{1'b1}};
          default: mac = rand_mac();
        endcase
        op = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_LOOKUP;
        if (sel < 42)      send_item(CMD_INSERT, ip, mac);
        else if (sel < 84) send_item(CMD_LOOKUP, ip, mac);
        else if (sel < 86) send_item(CMD_CLEAR, $urandom, mac);
        else if (sel < 89) send_item(CMD_NOP, $urandom, mac);
        else if (sel < 92) send_item(op, '0, mac);
        else if (sel < 95) send_item(op, BCAST_IP, mac);
        else               send_item(op, $urandom, mac);
      end
      wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [IP_W-1:0] cand;
    bit              dup;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;

    // distinct addresses, never zero or broadcast
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        cand = $urandom;
        dup  = (cand == '0) || (cand == BCAST_IP);
        for (int j = 0; j < i; j++) if (addr_pool[j] == cand) dup = 1'b1;
      end while (dup);
      addr_pool[i] = cand;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_table_full();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
